>>> hdl/stli_pkg.sv
// package for the adc to temperature lookup unit
// types, sensor voltage rom and fixed constants; no dependencies
package stli_pkg;

    localparam int TABLE_ROWS = 116;
    localparam int ADC_BITS   = 16;
    localparam int ROM_ROWS   = 116;
    localparam int ROM_IW     = 7;
    localparam int FIRST_TEMP = -5;
    localparam int ROWS       = (TABLE_ROWS > ROM_ROWS) ? ROM_ROWS :
                                ((TABLE_ROWS < 2) ? 2 : TABLE_ROWS);
    localparam int IDX_W      = $clog2(ROWS);
    localparam int PADDR_W    = 4;

    localparam logic [15:0] SAMPLE_MASK = 16'((32'd1 << ADC_BITS) - 1);

    localparam logic [5:0] MUL_STEPS  = 6'd20;
    localparam logic [5:0] DIV_STEPS  = 6'd36;
    localparam logic [5:0] FRAC_STEPS = 6'd4;
    localparam logic [31:0] TEN_RECIP = 32'd52429;

    typedef logic signed [12:0] t_temp;

    typedef enum logic [1:0] {
        REG_STEPS = 2'd0,
        REG_REF   = 2'd1,
        REG_UNIT  = 2'd2
    } t_reg;

    typedef struct packed {
        logic [15:0] steps;
        logic [12:0] ref_mv;
        logic        fahrenheit;
    } t_cfg;

    localparam logic [15:0] ROM_MV [ROM_ROWS] = '{
        16'd21540, 16'd21430, 16'd21320, 16'd21220, 16'd21110, 16'd21000, 16'd20890,
        16'd20790, 16'd20680, 16'd20570, 16'd20470, 16'd20360, 16'd20250, 16'd20140,
        16'd20040, 16'd19930, 16'd19820, 16'd19710, 16'd19610, 16'd19500, 16'd19390,
        16'd19280, 16'd19180, 16'd19070, 16'd18960, 16'd18850, 16'd18740, 16'd18640,
        16'd18530, 16'd18420, 16'd18310, 16'd18200, 16'd18100, 16'd17990, 16'd17880,
        16'd17770, 16'd17660, 16'd17560, 16'd17450, 16'd17340, 16'd17230, 16'd17120,
        16'd17010, 16'd16900, 16'd16790, 16'd16680, 16'd16570, 16'd16460, 16'd16350,
        16'd16240, 16'd16130, 16'd16020, 16'd15910, 16'd15800, 16'd15690, 16'd15580,
        16'd15470, 16'd15360, 16'd15250, 16'd15140, 16'd15030, 16'd14920, 16'd14810,
        16'd14700, 16'd14590, 16'd14480, 16'd14360, 16'd14250, 16'd14140, 16'd14030,
        16'd13910, 16'd13800, 16'd13690, 16'd13580, 16'd13460, 16'd13350, 16'd13240,
        16'd13130, 16'd13010, 16'd12900, 16'd12790, 16'd12680, 16'd12570, 16'd12450,
        16'd12340, 16'd12230, 16'd12120, 16'd12010, 16'd11890, 16'd11780, 16'd11670,
        16'd11550, 16'd11440, 16'd11330, 16'd11220, 16'd11100, 16'd10990, 16'd10880,
        16'd10760, 16'd10650, 16'd10540, 16'd10420, 16'd10310, 16'd10200, 16'd10080,
        16'd9970,  16'd9860,  16'd9740,  16'd9630,  16'd9510,  16'd9400,  16'd9290,
        16'd9170,  16'd9060,  16'd8950,  16'd8830
    };

    function automatic logic [15:0] rom_mv(input logic [ROM_IW-1:0] k);
        return ROM_MV[k];
    endfunction

    // row index to tenths of a degree celsius
    function automatic t_temp tenths_of(input logic [ROM_IW-1:0] k);
        logic [12:0] w;
        w = 13'(k);
        return t_temp'((w << 3) + (w << 1) - 13'(-FIRST_TEMP * 10));
    endfunction

endpackage

>>> hdl/stli_sample_if.sv
// input channel of the adc to temperature unit: one adc sample per item
// no dependencies
interface stli_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] adc_sample;
    modport source (output valid, output adc_sample, input ready);
    modport sink (input valid, input adc_sample, output ready);
endinterface

>>> hdl/stli_temp_if.sv
// output channel of the adc to temperature unit: one temperature per item
// no dependencies
interface stli_temp_if;
    logic               valid;
    logic               ready;
    logic signed [12:0] temperature_tenths;
    modport source (output valid, output temperature_tenths, input ready);
    modport sink (input valid, input temperature_tenths, output ready);
endinterface

>>> hdl/stli_cfg.sv
// apb register block: full scale steps, reference millivolts, unit select
// depends on stli_pkg
module stli_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [stli_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output stli_pkg::t_cfg               o_cfg
);
    import stli_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    t_reg w_reg;

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;
    assign w_reg  = t_reg'(paddr[3:2]);

    always_comb begin
        n_cfg = r_cfg;
        if (psel && penable && pwrite) begin
            unique case (w_reg)
                REG_STEPS: n_cfg.steps      = pwdata[15:0];
                REG_REF:   n_cfg.ref_mv     = pwdata[12:0];
                REG_UNIT:  n_cfg.fahrenheit = pwdata[0];
                default:   n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_STEPS: prdata = 32'(r_cfg.steps);
            REG_REF:   prdata = 32'(r_cfg.ref_mv);
            REG_UNIT:  prdata = 32'(r_cfg.fahrenheit);
            default:   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.steps      <= 16'd4096;
            r_cfg.ref_mv     <= 13'd3300;
            r_cfg.fahrenheit <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> hdl/sensor_adc_to_temperature_lut_interp_unit.sv
// channel    dir  payload                      handshake
// i_sample   in   adc_sample [15:0] unsigned   valid/ready
// o_temp     out  temperature_tenths [12:0] s  valid/ready
// apb        in   steps, reference mv, unit    psel/penable/pwrite, pready high
//
// one item at a time; a 20-step shift-add multiply
// and a 36-step restoring divide dominate, then up to 7 search steps and a
// 4-step fraction divide; saturated voltages skip the search
// synchronous active-low reset clears the sequencer and output valid
// a result waiting on o_temp does not stop the next item being accepted
// depends on stli_pkg, stli_sample_if, stli_temp_if, stli_cfg
module sensor_adc_to_temperature_lut_interp_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [stli_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    stli_sample_if.sink                  i_sample,
    stli_temp_if.source                  o_temp
);
    import stli_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL   = 9'b000000010,
        S_DIV   = 9'b000000100,
        S_RANGE = 9'b000001000,
        S_SRCH  = 9'b000010000,
        S_FRAC  = 9'b000100000,
        S_CMB   = 9'b001000000,
        S_UNIT  = 9'b010000000,
        S_SCALE = 9'b100000000
    } t_state;

    t_cfg w_cfg;

    t_state           r_state, n_state;
    logic             r_done, n_done;
    logic [15:0]      r_sample, n_sample;
    logic [19:0]      r_m, n_m;
    logic [35:0]      r_p, n_p;
    logic [19:0]      r_div, n_div;
    logic [19:0]      r_rem, n_rem;
    logic [5:0]       r_cnt, n_cnt;
    logic [IDX_W-1:0] r_lo, n_lo;
    logic [IDX_W-1:0] r_hi, n_hi;
    logic [19:0]      r_num, n_num;
    logic [18:0]      r_dsh, n_dsh;
    logic [3:0]       r_q, n_q;
    t_temp            r_c, n_c;
    logic [14:0]      r_x, n_x;
    t_temp            r_res, n_res;
    logic             r_out_valid, n_out_valid;
    t_temp            r_out, n_out;

    logic [15:0]      w_steps;
    logic [19:0]      w_ref;
    logic [20:0]      w_trial;
    logic [15:0]      w_v;
    logic [15:0]      w_d;
    logic [19:0]      w_d20;
    logic [15:0]      w_dd;
    logic [IDX_W-1:0] w_mid;
    logic [14:0]      w_c15;
    logic [31:0]      w_prod;

    stli_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign i_sample.ready            = (r_state == S_IDLE) && !r_done;
    assign o_temp.valid              = r_out_valid;
    assign o_temp.temperature_tenths = r_out;

    assign w_steps = (w_cfg.steps == 16'd0) ? 16'd1 : w_cfg.steps;
    assign w_ref   = 20'(w_cfg.ref_mv);
    assign w_trial = {r_rem, r_p[35]};
    assign w_v     = r_p[15:0];
    assign w_d     = rom_mv(ROM_IW'(r_lo)) - w_v;
    assign w_d20   = 20'(w_d);
    assign w_dd    = rom_mv(ROM_IW'(r_lo)) - rom_mv(ROM_IW'(r_hi));
    assign w_mid   = IDX_W'(({1'b0, r_hi} + {1'b0, r_lo}) >> 1);
    assign w_c15   = 15'(r_c);
    assign w_prod  = 32'(r_x) * TEN_RECIP;

    always_comb begin
        n_state     = r_state;
        n_done      = r_done;
        n_sample    = r_sample;
        n_m         = r_m;
        n_p         = r_p;
        n_div       = r_div;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_num       = r_num;
        n_dsh       = r_dsh;
        n_q         = r_q;
        n_c         = r_c;
        n_x         = r_x;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_temp.ready;

        // hand the finished item to the output register
        if (r_done && !r_out_valid) begin
            n_out_valid = 1'b1;
            n_out       = r_res;
            n_done      = 1'b0;
        end else if (r_done && o_temp.ready) begin
            n_out_valid = 1'b1;
            n_out       = r_res;
            n_done      = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_sample.valid && !r_done) begin
                    n_sample = i_sample.adc_sample & SAMPLE_MASK;
                    n_m      = (w_ref << 6) + (w_ref << 5) + (w_ref << 2);
                    n_div    = ({4'd0, w_steps} << 3) + ({4'd0, w_steps} << 1);
                    n_p      = '0;
                    n_cnt    = MUL_STEPS - 6'd1;
                    n_state  = S_MUL;
                end
            end
            S_MUL: begin
                n_p = {r_p[34:0], 1'b0} + (r_m[19] ? 36'(r_sample) : 36'd0);
                n_m = r_m << 1;
                if (r_cnt == 6'd0) begin
                    n_rem   = '0;
                    n_cnt   = DIV_STEPS - 6'd1;
                    n_state = S_DIV;
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end
            S_DIV: begin
                // quotient bits shift in where dividend bits leave
                if (w_trial >= {1'b0, r_div}) begin
                    n_rem = 20'(w_trial - {1'b0, r_div});
                    n_p   = {r_p[34:0], 1'b1};
                end else begin
                    n_rem = w_trial[19:0];
                    n_p   = {r_p[34:0], 1'b0};
                end
                if (r_cnt == 6'd0) begin
                    n_state = S_RANGE;
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end
            S_RANGE: begin
                priority if (r_p > 36'(rom_mv(ROM_IW'(0)))) begin
                    n_c     = tenths_of(ROM_IW'(0));
                    n_state = S_UNIT;
                end else if (r_p <= 36'(rom_mv(ROM_IW'(ROWS - 1)))) begin
                    n_c     = tenths_of(ROM_IW'(ROWS - 1));
                    n_state = S_UNIT;
                end else begin
                    n_lo    = '0;
                    n_hi    = IDX_W'(ROWS - 1);
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                // invariant: rom[lo] >= v > rom[hi]
                if (IDX_W'(r_hi - r_lo) == IDX_W'(1)) begin
                    if (w_d == 16'd0) begin
                        n_c     = tenths_of(ROM_IW'(r_lo));
                        n_state = S_UNIT;
                    end else begin
                        n_num   = (w_d20 << 3) + (w_d20 << 1);
                        n_dsh   = 19'({w_dd, 3'b000});
                        n_q     = '0;
                        n_cnt   = FRAC_STEPS - 6'd1;
                        n_state = S_FRAC;
                    end
                end else if (rom_mv(ROM_IW'(w_mid)) >= w_v) begin
                    n_lo = w_mid;
                end else begin
                    n_hi = w_mid;
                end
            end
            S_FRAC: begin
                if (r_num >= 20'(r_dsh)) begin
                    n_num = r_num - 20'(r_dsh);
                    n_q   = {r_q[2:0], 1'b1};
                end else begin
                    n_q   = {r_q[2:0], 1'b0};
                end
                n_dsh = r_dsh >> 1;
                if (r_cnt == 6'd0) begin
                    n_state = S_CMB;
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end
            S_CMB: begin
                // below zero degrees truncation toward zero rounds the fraction up
                n_c = tenths_of(ROM_IW'(r_lo)) + t_temp'(r_q)
                    + ((int'(r_lo) < -FIRST_TEMP && r_num != 20'd0) ? 13'sd1 : 13'sd0);
                n_state = S_UNIT;
            end
            S_UNIT: begin
                if (w_cfg.fahrenheit) begin
                    n_x     = (w_c15 << 4) + (w_c15 << 1) + 15'd3200;
                    n_state = S_SCALE;
                end else begin
                    n_res   = r_c;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SCALE: begin
                // divide by ten through the reciprocal, exact for this range
                n_res   = t_temp'({1'b0, w_prod[30:19]});
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_m      <= n_m;
        r_p      <= n_p;
        r_div    <= n_div;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_num    <= n_num;
        r_dsh    <= n_dsh;
        r_q      <= n_q;
        r_c      <= n_c;
        r_x      <= n_x;
        r_res    <= n_res;
        r_out    <= n_out;
    end

`ifndef SYNTHESIS
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_lo < r_hi))
        else $error("search bounds crossed");

    a_frac_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FRAC) |-> (r_num < {r_dsh, 1'b0}))
        else $error("fraction quotient digit overflow");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("finished item held outside idle");
`endif

endmodule

>>> verif/tb_sensor_adc_to_temperature_lut_interp_unit.sv
// testbench for the adc to temperature lookup unit: directed and random samples
// under several register settings, each result checked against a local predictor
// depends on stli_pkg, stli_sample_if, stli_temp_if and the unit itself
module tb_sensor_adc_to_temperature_lut_interp_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import stli_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int DRAIN_CYCLES   = 120;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    stli_sample_if sample_ch ();
    stli_temp_if   temp_ch ();

    sensor_adc_to_temperature_lut_interp_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_sample (sample_ch.source),
        .o_temp   (temp_ch.sink)
    );

    always #2 i_clk = ~i_clk;

    t_cfg  cur_cfg;
    t_temp temps_due[$];
    int    mismatches = 0;
    int    samples_sent = 0;
    int    temps_seen = 0;
    int    quiet_dead = 0;
    int    stall_left = 0;
    bit    idling_on = 1'b1;

    // expected temperature in tenths for one sample under the current settings
    function automatic t_temp predict_temp(input logic [15:0] sample, input t_cfg cfg);
        longint unsigned s;
        longint unsigned div;
        longint unsigned mv;
        longint c;
        longint t1;
        longint dv;
        longint r;
        int k;
        bit found;
        s = sample & SAMPLE_MASK;
        div = (cfg.steps == 0) ? 1 : cfg.steps;
        mv = ((s * cfg.ref_mv * 100) / div) / 10;
        found = 1'b0;
        c = FIRST_TEMP * 10;
        if (mv > ROM_MV[0]) begin
            c = FIRST_TEMP * 10;
        end else if (mv < ROM_MV[ROWS-1]) begin
            c = (FIRST_TEMP + ROWS - 1) * 10;
        end else begin
            for (k = 0; k < ROWS; k++) begin
                if (!found && mv == ROM_MV[k]) begin
                    c = (FIRST_TEMP + k) * 10;
                    found = 1'b1;
                end
            end
            for (k = 0; k + 1 < ROWS; k++) begin
                if (!found && mv < ROM_MV[k] && mv > ROM_MV[k+1]) begin
                    t1 = FIRST_TEMP + k;
                    dv = longint'(ROM_MV[k+1]) - longint'(ROM_MV[k]);
                    r = ((t1 * dv + (longint'(mv) - longint'(ROM_MV[k]))) * 100) / dv;
                    c = r / 10;
                    found = 1'b1;
                end
            end
        end
        if (cfg.fahrenheit) c = (c * 18 + 3200) / 10;
        return t_temp'(c);
    endfunction

    // consumer side: random stall bursts, checks every accepted temperature
    always @(posedge i_clk) begin
        if (temp_ch.valid && temp_ch.ready) begin
            temps_seen++;
            if (temps_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected temperature %0d", temp_ch.temperature_tenths);
            end else begin
                if (temp_ch.temperature_tenths !== temps_due[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("temperature mismatch: expected %0d got %0d",
                                 temps_due[0], temp_ch.temperature_tenths);
                end
                void'(temps_due.pop_front());
            end
        end
        if (!i_rst_n) begin
            temp_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            temp_ch.ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 16);
            temp_ch.ready <= 1'b0;
        end else begin
            temp_ch.ready <= 1'b1;
        end
    end

    // counts cycles in which nothing is accepted anywhere
    always @(posedge i_clk) begin
        if (!i_rst_n || (sample_ch.valid && sample_ch.ready) ||
            (temp_ch.valid && temp_ch.ready) || (psel && penable)) begin
            quiet_dead <= 0;
        end else if (quiet_dead >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_dead <= quiet_dead + 1;
        end
    end

    task automatic send_sample(input logic [15:0] sample);
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.adc_sample <= sample;
        @(posedge i_clk);
        while (!sample_ch.ready) @(posedge i_clk);
        temps_due.push_back(predict_temp(sample, cur_cfg));
        samples_sent++;
    endtask

    task automatic end_samples();
        sample_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        while (temps_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg idx, input logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= PADDR_W'(4 * int'(idx));
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_STEPS: cur_cfg.steps = value[15:0];
            REG_REF:   cur_cfg.ref_mv = value[12:0];
            default:   cur_cfg.fahrenheit = value[0];
        endcase
    endtask

    task automatic set_config(input logic [15:0] steps, input logic [12:0] ref_mv,
                              input logic fahr);
        end_samples();
        wait_idle();
        write_reg(REG_STEPS, 32'(steps));
        write_reg(REG_REF, 32'(ref_mv));
        write_reg(REG_UNIT, 32'(fahr));
        @(posedge i_clk);
    endtask

    // with steps 1000 and reference 1000 the scaled voltage is ten times the sample
    task automatic test_directed();
        send_sample(16'd0);
        send_sample(16'hFFFF);
        set_config(16'd1000, 13'd1000, 1'b0);
        send_sample(16'd2154);
        send_sample(16'd2155);
        send_sample(16'd883);
        send_sample(16'd882);
        send_sample(16'd2000);
        send_sample(16'd2153);
        send_sample(16'd884);
        send_sample(16'd1500);
        set_config(16'd1000, 13'd1000, 1'b1);
        send_sample(16'd2154);
        send_sample(16'd2155);
        send_sample(16'd882);
        send_sample(16'd1777);
        // zero divisor behaves as one
        set_config(16'd0, 13'd1, 1'b0);
        send_sample(16'd215);
        send_sample(16'd100);
        send_sample(16'd1);
        set_config(16'hFFFF, 13'h1FFF, 1'b0);
        send_sample(16'hFFFF);
        send_sample(16'd1);
    endtask

    // most samples are aimed into the table span, the rest are arbitrary
    task automatic test_random_phase(input int count);
        longint unsigned aim;
        logic [15:0] sample;
        int n;
        for (n = 0; n < count; n++) begin
            if ($urandom_range(0, 3) != 0 && cur_cfg.ref_mv != 0) begin
                aim = $urandom_range(8700, 21700);
                aim = (aim * ((cur_cfg.steps == 0) ? 1 : cur_cfg.steps)) /
                      (longint'(cur_cfg.ref_mv) * 10) + $urandom_range(0, 1);
                sample = (aim > 65535) ? 16'hFFFF : 16'(aim);
            end else begin
                sample = 16'($urandom);
            end
            send_sample(sample);
        end
    endtask

    task automatic test_settings();
        set_config(16'd65535, 13'd5000, 1'b0);
        test_random_phase(100);
        set_config(16'd1, 13'd1, 1'b1);
        test_random_phase(60);
        set_config(16'd4096, 13'd3300, 1'b1);
        test_random_phase(100);
        set_config(16'd1023, 13'd8191, 1'b0);
        test_random_phase(100);
        repeat (3) begin
            set_config(16'($urandom), 13'($urandom), 1'($urandom));
            test_random_phase(100);
        end
    endtask

    task automatic test_no_idling();
        set_config(16'd4096, 13'd3300, 1'b0);
        idling_on = 1'b0;
        test_random_phase(120);
    endtask

    initial begin
        sample_ch.valid = 1'b0;
        sample_ch.adc_sample = '0;
        cur_cfg.steps = 16'd4096;
        cur_cfg.ref_mv = 13'd3300;
        cur_cfg.fahrenheit = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_settings();
        test_no_idling();
        end_samples();
        wait_idle();
        $display("samples sent %0d, temperatures checked %0d, mismatches %0d",
                 samples_sent, temps_seen, mismatches);
        $display("covered table ends, row hits, interpolation, both units, zero divisor");
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
